@@ rtl/tpsg_pkg.sv @@
// shared constants, types and functions of the turtle pen segment generator
`default_nettype none
package tpsg_pkg;
    localparam int CoordBits = 24;
    localparam int AngleBits = 26;
    localparam int SidesBits = 7;
    localparam int MaxSides = 64;
    localparam int TrigIterations = 16;
    localparam int TrigBits = 33;
    localparam int IterBits = 5;
    localparam int ZBits = 28;
    localparam logic signed [TrigBits-1:0] CordicStart = 33'sd652032874;
    localparam logic signed [ZBits-1:0] DegQ16 = 28'sd65536;
    localparam logic signed [ZBits-1:0] FullTurn = 28'sd23592960;
    localparam logic signed [ZBits-1:0] HalfTurn = 28'sd11796480;
    localparam logic signed [ZBits-1:0] QuarterTurn = 28'sd5898240;
    localparam int TurnQ16 = 23592960;

    // per-side turn 360/n in q.16, rounded, indexed by n
    localparam logic [MaxSides:0][AngleBits-1:0] StepTurn = {
        AngleBits'((TurnQ16 + 32) / 64), AngleBits'((TurnQ16 + 31) / 63),
        AngleBits'((TurnQ16 + 31) / 62), AngleBits'((TurnQ16 + 30) / 61),
        AngleBits'((TurnQ16 + 30) / 60), AngleBits'((TurnQ16 + 29) / 59),
        AngleBits'((TurnQ16 + 29) / 58), AngleBits'((TurnQ16 + 28) / 57),
        AngleBits'((TurnQ16 + 28) / 56), AngleBits'((TurnQ16 + 27) / 55),
        AngleBits'((TurnQ16 + 27) / 54), AngleBits'((TurnQ16 + 26) / 53),
        AngleBits'((TurnQ16 + 26) / 52), AngleBits'((TurnQ16 + 25) / 51),
        AngleBits'((TurnQ16 + 25) / 50), AngleBits'((TurnQ16 + 24) / 49),
        AngleBits'((TurnQ16 + 24) / 48), AngleBits'((TurnQ16 + 23) / 47),
        AngleBits'((TurnQ16 + 23) / 46), AngleBits'((TurnQ16 + 22) / 45),
        AngleBits'((TurnQ16 + 22) / 44), AngleBits'((TurnQ16 + 21) / 43),
        AngleBits'((TurnQ16 + 21) / 42), AngleBits'((TurnQ16 + 20) / 41),
        AngleBits'((TurnQ16 + 20) / 40), AngleBits'((TurnQ16 + 19) / 39),
        AngleBits'((TurnQ16 + 19) / 38), AngleBits'((TurnQ16 + 18) / 37),
        AngleBits'((TurnQ16 + 18) / 36), AngleBits'((TurnQ16 + 17) / 35),
        AngleBits'((TurnQ16 + 17) / 34), AngleBits'((TurnQ16 + 16) / 33),
        AngleBits'((TurnQ16 + 16) / 32), AngleBits'((TurnQ16 + 15) / 31),
        AngleBits'((TurnQ16 + 15) / 30), AngleBits'((TurnQ16 + 14) / 29),
        AngleBits'((TurnQ16 + 14) / 28), AngleBits'((TurnQ16 + 13) / 27),
        AngleBits'((TurnQ16 + 13) / 26), AngleBits'((TurnQ16 + 12) / 25),
        AngleBits'((TurnQ16 + 12) / 24), AngleBits'((TurnQ16 + 11) / 23),
        AngleBits'((TurnQ16 + 11) / 22), AngleBits'((TurnQ16 + 10) / 21),
        AngleBits'((TurnQ16 + 10) / 20), AngleBits'((TurnQ16 + 9) / 19),
        AngleBits'((TurnQ16 + 9) / 18), AngleBits'((TurnQ16 + 8) / 17),
        AngleBits'((TurnQ16 + 8) / 16), AngleBits'((TurnQ16 + 7) / 15),
        AngleBits'((TurnQ16 + 7) / 14), AngleBits'((TurnQ16 + 6) / 13),
        AngleBits'((TurnQ16 + 6) / 12), AngleBits'((TurnQ16 + 5) / 11),
        AngleBits'((TurnQ16 + 5) / 10), AngleBits'((TurnQ16 + 4) / 9),
        AngleBits'((TurnQ16 + 4) / 8), AngleBits'((TurnQ16 + 3) / 7),
        AngleBits'((TurnQ16 + 3) / 6), AngleBits'((TurnQ16 + 2) / 5),
        AngleBits'((TurnQ16 + 2) / 4), AngleBits'((TurnQ16 + 1) / 3),
        AngleBits'(0), AngleBits'(0), AngleBits'(0)
    };

    typedef enum logic [2:0] {
        OP_SET_POSE = 3'd0,
        OP_TURN     = 3'd1,
        OP_ADVANCE  = 3'd2,
        OP_POLY     = 3'd3,
        OP_POLY_C   = 3'd4
    } t_op;

    function automatic logic signed [ZBits-1:0] atan_deg(input logic [IterBits-1:0] i);
        logic signed [ZBits-1:0] v;
        case (i)
            5'd0: v = 28'sd2949120;  5'd1: v = 28'sd1740967;
            5'd2: v = 28'sd919879;   5'd3: v = 28'sd466945;
            5'd4: v = 28'sd234379;   5'd5: v = 28'sd117304;
            5'd6: v = 28'sd58666;    5'd7: v = 28'sd29335;
            5'd8: v = 28'sd14668;    5'd9: v = 28'sd7334;
            5'd10: v = 28'sd3667;    5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;     5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;     5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;      5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;      5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;       5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // per-side turn 360/n in q.16, rounded, for n in 3..64
    function automatic logic signed [AngleBits-1:0] step_angle(input logic [SidesBits-1:0] n);
        return StepTurn[n];
    endfunction

    function automatic logic signed [CoordBits-1:0] sat_coord(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd8388607;
        lo = -48'sd8388608;
        if (v > hi) return CoordBits'(hi);
        if (v < lo) return CoordBits'(lo);
        return v[CoordBits-1:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/turtle_pen_segment_generator_unit.sv @@
// top level of the turtle pen segment generator
// channel  | direction | handshake
// request  | in        | i_valid / o_ready
// segment  | out       | o_valid / i_ready
// an advance runs from request to next request through decode, cordic launch,
// fold, 16 cordic steps and handoff, the multiply states and the output state
// a polygon runs decode, then per side the advance states and a turn; by centre adds the centre states up front
// set pose and turn pass through decode, turn adds a turn state; reset returns the pen to the origin at heading 0
// a stalled segment holds the sequencer until it is taken
`default_nettype none
module turtle_pen_segment_generator_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [2:0]                            i_op,
    input  wire logic signed [23:0]                    i_pos_x,
    input  wire logic signed [23:0]                    i_pos_y,
    input  wire logic signed [25:0]                    i_angle,
    input  wire logic signed [23:0]                    i_length,
    input  wire logic                                  i_visible,
    input  wire logic [6:0]                            i_sides,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [23:0]                         o_start_x,
    output logic signed [23:0]                         o_start_y,
    output logic signed [23:0]                         o_end_x,
    output logic signed [23:0]                         o_end_y,
    output logic                                       o_drawn,
    output logic                                       o_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TURN, S_CTR_TRIG, S_CTR_WAIT, S_CTR_MX, S_CTR_MY, S_CTR_MS,
        S_CTR_END, S_ADV_TRIG, S_ADV_WAIT, S_ADV_MX, S_ADV_MY, S_ADV_END, S_OUT, S_POLY_TURN
    } t_state;

    t_state r_state;
    logic signed [23:0] r_pen_x, r_pen_y, r_side_length;
    logic signed [25:0] r_heading, r_step_turn, r_turn_inc;
    logic [6:0] r_sides_left, r_n;
    logic [2:0] r_op;
    logic signed [23:0] r_px, r_py, r_len;
    logic r_vis, r_poly;
    logic r_trig_start;
    logic trig_done;
    logic signed [tpsg_pkg::TrigBits-1:0] trig_cos, trig_sin;
    logic signed [tpsg_pkg::ZBits-1:0] r_trig_angle;
    logic signed [tpsg_pkg::TrigBits-1:0] r_mul_b;
    logic signed [24:0] r_mul_a;
    logic signed [57:0] r_prod;
    logic signed [26:0] n_sum;
    logic signed [26:0] n_ip, n_frac;
    logic signed [26:0] n_mag, n_rem;
    logic signed [26:0] n_head;
    logic signed [57:0] n_prod;
    logic signed [27:0] n_round;
    logic [6:0] n_clamp;

    tpsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_trig_start),
        .i_angle (r_trig_angle),
        .o_done  (trig_done),
        .o_cos   (trig_cos),
        .o_sin   (trig_sin)
    );

    always_comb begin
        n_sum = 27'(r_heading) + 27'(r_turn_inc);
        n_ip = n_sum / 27'sd65536;
        n_frac = n_sum - n_ip * 27'sd65536;
        // integer degrees stay within three turns, so two compares reduce them
        n_mag = (n_ip < 0) ? -n_ip : n_ip;
        if (n_mag >= 27'sd720) n_mag = n_mag - 27'sd720;
        else if (n_mag >= 27'sd360) n_mag = n_mag - 27'sd360;
        n_rem = (n_ip < 0) ? -n_mag : n_mag;
        n_head = n_rem * 27'sd65536 + n_frac;
        n_prod = r_mul_a * r_mul_b;
        n_round = 28'((r_prod + 58'sd536870912) >>> 30);
        if (i_sides < 7'd3) n_clamp = 7'd3;
        else if (i_sides > 7'(tpsg_pkg::MaxSides)) n_clamp = 7'(tpsg_pkg::MaxSides);
        else n_clamp = i_sides;
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pen_x <= '0;
            r_pen_y <= '0;
            r_heading <= '0;
            r_sides_left <= '0;
            r_step_turn <= '0;
            r_side_length <= '0;
            r_trig_start <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_trig_start <= 1'b0;
            r_prod <= n_prod;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_op;
                        r_px <= i_pos_x;
                        r_py <= i_pos_y;
                        r_turn_inc <= i_angle;
                        r_len <= i_length;
                        r_vis <= i_visible;
                        r_n <= n_clamp;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (r_op)
                        tpsg_pkg::OP_SET_POSE: begin
                            r_pen_x <= r_px;
                            r_pen_y <= r_py;
                            r_heading <= r_turn_inc;
                            r_state <= S_IDLE;
                        end
                        tpsg_pkg::OP_TURN: r_state <= S_TURN;
                        tpsg_pkg::OP_ADVANCE: begin
                            r_poly <= 1'b0;
                            r_side_length <= r_side_length;
                            r_state <= S_ADV_TRIG;
                        end
                        tpsg_pkg::OP_POLY: begin
                            r_step_turn <= tpsg_pkg::step_angle(r_n);
                            r_poly <= 1'b1;
                            r_vis <= 1'b1;
                            r_len <= r_len;
                            r_side_length <= r_len;
                            r_sides_left <= r_n;
                            r_state <= S_ADV_TRIG;
                        end
                        tpsg_pkg::OP_POLY_C: begin
                            r_step_turn <= tpsg_pkg::step_angle(r_n);
                            r_poly <= 1'b1;
                            r_vis <= 1'b1;
                            r_sides_left <= r_n;
                            r_state <= S_CTR_TRIG;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_TURN: begin
                    r_heading <= n_head[25:0];
                    r_state <= S_IDLE;
                end
                S_CTR_TRIG: begin
                    r_trig_angle <= (tpsg_pkg::HalfTurn - 28'(r_step_turn)) / 28'sd2;
                    r_trig_start <= 1'b1;
                    r_state <= S_CTR_WAIT;
                end
                S_CTR_WAIT: begin
                    if (trig_done) begin
                        r_mul_a <= 25'(r_len);
                        r_mul_b <= trig_cos;
                        r_state <= S_CTR_MX;
                    end
                end
                S_CTR_MX: begin
                    r_mul_b <= trig_sin;
                    r_state <= S_CTR_MY;
                end
                S_CTR_MY: begin
                    r_pen_x <= tpsg_pkg::sat_coord(48'(r_px) + 48'(n_round));
                    r_mul_a <= 25'(r_len) <<< 1;
                    r_mul_b <= trig_cos;
                    r_state <= S_CTR_MS;
                end
                S_CTR_MS: begin
                    r_pen_y <= tpsg_pkg::sat_coord(48'(r_py) - 48'(n_round));
                    r_state <= S_CTR_END;
                end
                S_CTR_END: begin
                    r_side_length <= tpsg_pkg::sat_coord(48'(n_round));
                    r_len <= tpsg_pkg::sat_coord(48'(n_round));
                    r_heading <= r_step_turn;
                    r_state <= S_ADV_TRIG;
                end
                S_ADV_TRIG: begin
                    r_trig_angle <= 28'(r_heading);
                    r_trig_start <= 1'b1;
                    r_state <= S_ADV_WAIT;
                end
                S_ADV_WAIT: begin
                    if (trig_done) begin
                        r_mul_a <= 25'(r_poly ? r_side_length : r_len);
                        r_mul_b <= trig_cos;
                        r_state <= S_ADV_MX;
                    end
                end
                S_ADV_MX: begin
                    r_mul_b <= trig_sin;
                    r_state <= S_ADV_MY;
                end
                S_ADV_MY: begin
                    o_end_x <= tpsg_pkg::sat_coord(48'(r_pen_x) + 48'(n_round));
                    r_state <= S_ADV_END;
                end
                S_ADV_END: begin
                    o_end_y <= tpsg_pkg::sat_coord(48'(r_pen_y) + 48'(n_round));
                    o_start_x <= r_pen_x;
                    o_start_y <= r_pen_y;
                    o_drawn <= r_vis;
                    o_last <= !r_poly || (r_sides_left == 7'd1);
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_pen_x <= o_end_x;
                        r_pen_y <= o_end_y;
                        if (r_poly) begin
                            r_turn_inc <= r_step_turn;
                            r_state <= S_POLY_TURN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_POLY_TURN: begin
                    r_heading <= n_head[25:0];
                    r_sides_left <= r_sides_left - 7'd1;
                    r_state <= (r_sides_left == 7'd1) ? S_IDLE : S_ADV_TRIG;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> r_state == S_OUT)
        else $error("segment shown outside output state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !o_ready)
        else $error("request taken while a segment waits");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POLY_TURN) |-> r_sides_left != 7'd0)
        else $error("polygon side count underflow");
endmodule
`default_nettype wire

@@ rtl/tpsg_cordic.sv @@
// iterative cordic: cosine and sine in q.30 of a q.16 degree angle
`default_nettype none
module tpsg_cordic (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_start,
    input  wire logic signed [tpsg_pkg::ZBits-1:0]       i_angle,
    output logic                                         o_done,
    output logic signed [tpsg_pkg::TrigBits-1:0]         o_cos,
    output logic signed [tpsg_pkg::TrigBits-1:0]         o_sin
);
    typedef enum logic [1:0] {S_IDLE, S_FOLD, S_ITER, S_OUT} t_state;
    t_state r_state;
    logic signed [tpsg_pkg::ZBits-1:0] r_z;
    logic signed [tpsg_pkg::TrigBits-1:0] r_x, r_y;
    logic r_neg;
    logic [tpsg_pkg::IterBits-1:0] r_i;
    logic signed [tpsg_pkg::ZBits-1:0] n_r;

    // reduce into one full turn, angles stay below two turns in magnitude
    always_comb begin
        n_r = r_z;
        if (n_r >= tpsg_pkg::FullTurn) n_r = n_r - tpsg_pkg::FullTurn;
        else if (n_r <= -tpsg_pkg::FullTurn) n_r = n_r + tpsg_pkg::FullTurn;
        if (n_r < 0) n_r = n_r + tpsg_pkg::FullTurn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_z <= i_angle;
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_x <= tpsg_pkg::CordicStart;
                    r_y <= '0;
                    r_i <= '0;
                    r_neg <= 1'b0;
                    if (n_r > tpsg_pkg::QuarterTurn && n_r <= 3 * tpsg_pkg::QuarterTurn) begin
                        r_z <= n_r - tpsg_pkg::HalfTurn;
                        r_neg <= 1'b1;
                    end else if (n_r > 3 * tpsg_pkg::QuarterTurn) begin
                        r_z <= n_r - tpsg_pkg::FullTurn;
                    end else begin
                        r_z <= n_r;
                    end
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - tpsg_pkg::atan_deg(r_i);
                    end else begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + tpsg_pkg::atan_deg(r_i);
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == tpsg_pkg::IterBits'(tpsg_pkg::TrigIterations - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    o_cos <= r_neg ? -r_x : r_x;
                    o_sin <= r_neg ? -r_y : r_y;
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
